FILE: hdl/cpt_pkg.sv
// shared widths, payload types and region codes for the closest point block
package cpt_pkg;

   localparam int CW   = 16;            // coordinate width
   localparam int DIFW = CW + 1;        // vertex differences
   localparam int PPW  = 2 * DIFW;      // product of two differences
   localparam int PDW  = PPW + 2;       // edge projections
   localparam int CRW  = PPW + 1;       // normal
   localparam int NPW  = CRW + DIFW;    // normal times edge
   localparam int NEW  = NPW + 1;       // edge plane normals
   localparam int DPW  = NEW + DIFW;    // plane distance products
   localparam int DOTW = DPW + 2;       // plane distances
   localparam int WW   = DOTW - 1;      // clamped weights, never negative
   localparam int LOW  = (WW + 1) / 2;  // low slice of a weight
   localparam int HIW  = WW - LOW;      // high slice of a weight
   localparam int WPW  = WW + CW + 1;   // weight times coordinate
   localparam int DENW = WW + 2;        // weight sum
   localparam int NUMW = WW + CW + 2;   // weighted coordinate sum
   localparam int RW   = NUMW + 2;      // divider remainder
   localparam int QW   = CW + 1;        // quotient bits
   localparam int QD   = 16;            // queue depth, power of two
   localparam int QAW  = $clog2(QD);
   localparam int QCW  = $clog2(QD + 1);

   // cyclic axis neighbors for cross products
   localparam int NXT1 [3] = '{1, 2, 0};
   localparam int NXT2 [3] = '{2, 0, 1};

   typedef enum logic [1:0] {
      RGN_INSIDE = 2'd0,
      RGN_AB     = 2'd1,
      RGN_BC     = 2'd2,
      RGN_CA     = 2'd3
   } region_type;

   typedef struct packed {
      logic signed [CW-1:0] vert_a_x;
      logic signed [CW-1:0] vert_a_y;
      logic signed [CW-1:0] vert_a_z;
      logic signed [CW-1:0] vert_b_x;
      logic signed [CW-1:0] vert_b_y;
      logic signed [CW-1:0] vert_b_z;
      logic signed [CW-1:0] vert_c_x;
      logic signed [CW-1:0] vert_c_y;
      logic signed [CW-1:0] vert_c_z;
      logic signed [CW-1:0] query_x;
      logic signed [CW-1:0] query_y;
      logic signed [CW-1:0] query_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic [1:0]           region_code;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [WW-1:0]       wa;
      logic [WW-1:0]       wb;
      logic [WW-1:0]       wc;
      logic [8:0][CW-1:0]  vtx;     // vertex*3 + axis
      region_type          region;
   } qent_type;

endpackage

FILE: hdl/cpt_front.sv
// front pipeline: edge planes, projections, region choice and clamped weights
module cpt_front import cpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req,
   output logic     push,
   output qent_type ent
);

   // dot product operand tables: ap.ab, bp.bc, cp.ca, bp.ab, cp.bc, ap.ca
   localparam int DOTU [6] = '{3, 4, 5, 4, 5, 3};
   localparam int DOTV [6] = '{0, 1, 2, 0, 1, 2};

   logic signed [CW-1:0]   co [12];
   logic [8:0][CW-1:0]     vt_in;
   logic [7:1]             v_ff;

   logic signed [DIFW-1:0] df1_in [6][3];
   logic signed [DIFW-1:0] df1_ff [6][3];
   logic signed [DIFW-1:0] df2_ff [6][3];
   logic signed [DIFW-1:0] df3_ff [6][3];
   logic signed [DIFW-1:0] df4_ff [6][3];
   logic signed [DIFW-1:0] df5_ff [6][3];
   logic [8:0][CW-1:0]     vt1_ff, vt2_ff, vt3_ff, vt4_ff, vt5_ff, vt6_ff, vt7_ff;

   logic signed [PPW-1:0]  np2_in [3][2];
   logic signed [PPW-1:0]  np2_ff [3][2];
   logic signed [PPW-1:0]  dp2_in [6][3];
   logic signed [PPW-1:0]  dp2_ff [6][3];

   logic signed [CRW-1:0]  n3_in [3];
   logic signed [CRW-1:0]  n3_ff [3];
   logic signed [PDW-1:0]  dt3_in [6];
   logic signed [PDW-1:0]  dt3_ff [6];
   logic signed [PDW-1:0]  dt4_ff [6];
   logic signed [PDW-1:0]  dt5_ff [6];
   logic signed [PDW-1:0]  dt6_ff [6];
   logic signed [PDW-1:0]  dt7_ff [6];

   logic signed [NPW-1:0]  mp4_in [3][3][2];
   logic signed [NPW-1:0]  mp4_ff [3][3][2];
   logic signed [NEW-1:0]  ne5_in [3][3];
   logic signed [NEW-1:0]  ne5_ff [3][3];
   logic signed [DPW-1:0]  dq6_in [3][3];
   logic signed [DPW-1:0]  dq6_ff [3][3];
   logic signed [DOTW-1:0] dd7_in [3];
   logic signed [DOTW-1:0] dd7_ff [3];

   logic signed [PDW-1:0]  pab, pbc, pca, qab, qbc, qca;
   logic signed [DOTW-1:0] dab, dbc, dca;
   logic signed [DOTW-1:0] wa_s, wb_s, wc_s;
   logic                   eab, ebc, eca, oab, obc, oca, onone;

   assign co[0]  = req.vert_a_x;
   assign co[1]  = req.vert_a_y;
   assign co[2]  = req.vert_a_z;
   assign co[3]  = req.vert_b_x;
   assign co[4]  = req.vert_b_y;
   assign co[5]  = req.vert_b_z;
   assign co[6]  = req.vert_c_x;
   assign co[7]  = req.vert_c_y;
   assign co[8]  = req.vert_c_z;
   assign co[9]  = req.query_x;
   assign co[10] = req.query_y;
   assign co[11] = req.query_z;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         vt_in[i] = co[i];
      end
      for (int ax = 0; ax < 3; ax++) begin
         df1_in[0][ax] = DIFW'(co[3+ax]) - DIFW'(co[ax]);
         df1_in[1][ax] = DIFW'(co[6+ax]) - DIFW'(co[3+ax]);
         df1_in[2][ax] = DIFW'(co[ax])   - DIFW'(co[6+ax]);
         df1_in[3][ax] = DIFW'(co[9+ax]) - DIFW'(co[ax]);
         df1_in[4][ax] = DIFW'(co[9+ax]) - DIFW'(co[3+ax]);
         df1_in[5][ax] = DIFW'(co[9+ax]) - DIFW'(co[6+ax]);
      end
   end

   // normal products and edge projection products
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         np2_in[ax][0] = df1_ff[0][NXT1[ax]] * df1_ff[1][NXT2[ax]];
         np2_in[ax][1] = df1_ff[0][NXT2[ax]] * df1_ff[1][NXT1[ax]];
      end
      for (int k = 0; k < 6; k++) begin
         for (int ax = 0; ax < 3; ax++) begin
            dp2_in[k][ax] = df1_ff[DOTU[k]][ax] * df1_ff[DOTV[k]][ax];
         end
      end
   end

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         n3_in[ax] = CRW'(np2_ff[ax][0]) - CRW'(np2_ff[ax][1]);
      end
      for (int k = 0; k < 6; k++) begin
         dt3_in[k] = PDW'(dp2_ff[k][0]) + PDW'(dp2_ff[k][1]) + PDW'(dp2_ff[k][2]);
         if (k >= 3) begin
            dt3_in[k] = PDW'(0) - dt3_in[k];
         end
      end
   end

   // edge plane normals n x ab, n x bc, n x ca
   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int ax = 0; ax < 3; ax++) begin
            mp4_in[e][ax][0] = n3_ff[NXT1[ax]] * df3_ff[e][NXT2[ax]];
            mp4_in[e][ax][1] = n3_ff[NXT2[ax]] * df3_ff[e][NXT1[ax]];
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int ax = 0; ax < 3; ax++) begin
            ne5_in[e][ax] = NEW'(mp4_ff[e][ax][0]) - NEW'(mp4_ff[e][ax][1]);
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int ax = 0; ax < 3; ax++) begin
            dq6_in[e][ax] = df5_ff[3+e][ax] * ne5_ff[e][ax];
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         dd7_in[e] = DOTW'(dq6_ff[e][0]) + DOTW'(dq6_ff[e][1]) + DOTW'(dq6_ff[e][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[6:1], take};
      end
   end

   always_ff @(posedge clock) begin
      df1_ff <= df1_in;
      vt1_ff <= vt_in;
      np2_ff <= np2_in;
      dp2_ff <= dp2_in;
      df2_ff <= df1_ff;
      vt2_ff <= vt1_ff;
      n3_ff  <= n3_in;
      dt3_ff <= dt3_in;
      df3_ff <= df2_ff;
      vt3_ff <= vt2_ff;
      mp4_ff <= mp4_in;
      dt4_ff <= dt3_ff;
      df4_ff <= df3_ff;
      vt4_ff <= vt3_ff;
      ne5_ff <= ne5_in;
      dt5_ff <= dt4_ff;
      df5_ff <= df4_ff;
      vt5_ff <= vt4_ff;
      dq6_ff <= dq6_in;
      dt6_ff <= dt5_ff;
      vt6_ff <= vt5_ff;
      dd7_ff <= dd7_in;
      dt7_ff <= dt6_ff;
      vt7_ff <= vt6_ff;
   end

   // region choice, edge ab first, then bc, then ca
   always_comb begin
      pab = dt7_ff[0];
      pbc = dt7_ff[1];
      pca = dt7_ff[2];
      qab = dt7_ff[3];
      qbc = dt7_ff[4];
      qca = dt7_ff[5];
      dab = dd7_ff[0];
      dbc = dd7_ff[1];
      dca = dd7_ff[2];

      eab = !pab[PDW-1] ? ((dab[DOTW-1] || dab == '0) && !(qab[PDW-1] || qab == '0))
                        : (qca[PDW-1] || qca == '0);
      ebc = !pbc[PDW-1] ? ((dbc[DOTW-1] || dbc == '0) && !(qbc[PDW-1] || qbc == '0))
                        : (qab[PDW-1] || qab == '0);
      eca = !pca[PDW-1] ? ((dca[DOTW-1] || dca == '0) && !(qca[PDW-1] || qca == '0))
                        : (qbc[PDW-1] || qbc == '0);
      oab   = eab;
      obc   = !oab && ebc;
      oca   = !oab && !obc && eca;
      onone = !oab && !obc && !oca;

      wa_s = oab ? DOTW'(qab) : oca ? DOTW'(pca) : onone ? dbc : '0;
      wb_s = oab ? DOTW'(pab) : obc ? DOTW'(qbc) : onone ? dca : '0;
      wc_s = obc ? DOTW'(pbc) : oca ? DOTW'(qca) : onone ? dab : '0;

      ent.wa  = wa_s[DOTW-1] ? '0 : wa_s[WW-1:0];
      ent.wb  = wb_s[DOTW-1] ? '0 : wb_s[WW-1:0];
      ent.wc  = wc_s[DOTW-1] ? '0 : wc_s[WW-1:0];
      ent.vtx = vt7_ff;
      ent.region = oab ? RGN_AB : obc ? RGN_BC : oca ? RGN_CA : RGN_INSIDE;
   end

   assign push = v_ff[7];

endmodule

FILE: hdl/cpt_queue.sv
// queue between front and back, with credits so the front never overruns it
module cpt_queue import cpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  logic     push,
   input  qent_type wr_ent,
   output logic     busy,
   output logic     rd_valid,
   output qent_type rd_ent
);

   qent_type       mem_ff [QD];
   qent_type       rd_ent_ff;
   logic           rd_valid_ff;
   logic [QAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCW-1:0] cnt_ff, cnt_in, crd_ff, crd_in;
   logic           pop;

   assign pop  = cnt_ff != '0;
   assign busy = crd_ff == QCW'(QD);

   // credits count beats taken in and not yet popped, in flight included
   always_comb begin
      wp_in  = push ? QAW'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? QAW'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = QCW'(cnt_ff + 1'b1);
      end else if (!push && pop) begin
         cnt_in = QCW'(cnt_ff - 1'b1);
      end
      crd_in = crd_ff;
      if (take && !pop) begin
         crd_in = QCW'(crd_ff + 1'b1);
      end else if (!take && pop) begin
         crd_in = QCW'(crd_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         cnt_ff      <= '0;
         crd_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         cnt_ff      <= cnt_in;
         crd_ff      <= crd_in;
         rd_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wr_ent;
      end
      if (pop) begin
         rd_ent_ff <= mem_ff[rp_ff];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_ent   = rd_ent_ff;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff != QCW'(QD))
      else $error("queue written while full");

   a_cnt_in_credit : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= crd_ff)
      else $error("queue holds more beats than credits");

   a_take_credit : assert property (@(posedge clock) disable iff (reset)
      take |=> crd_ff != '0)
      else $error("accepted beat left no credit");

endmodule

FILE: hdl/cpt_back.sv
// back pipeline: weighted sums, rounding divider and saturation
module cpt_back import cpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  qent_type ent,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   logic [WW-1:0]                wt [3];
   logic [3:1]                   bv_ff;

   logic signed [LOW+CW:0]       pl1_in [3][3];
   logic signed [LOW+CW:0]       pl1_ff [3][3];
   logic signed [HIW+CW:0]       ph1_in [3][3];
   logic signed [HIW+CW:0]       ph1_ff [3][3];
   logic [DENW-1:0]              den1_in, den1_ff, den2_ff;
   logic [2:0][CW-1:0]           va1_ff, va2_ff;
   region_type                   rg1_ff, rg2_ff, rg3_ff;

   logic signed [WPW-1:0]        wp2_in [3][3];
   logic signed [WPW-1:0]        wp2_ff [3][3];

   logic signed [NUMW-1:0]       num3_in [3];
   logic signed [NUMW-1:0]       num3_ff [3];
   logic [DENW-1:0]              den3_in, den3_ff;

   logic [NUMW-1:0]              mag [3];

   // divider stages, index 0 is the load stage
   logic [RW-1:0]                rm_ff [QW+1][3];
   logic [RW-1:0]                rm_in [QW+1][3];
   logic [QW-1:0]                qq_ff [QW+1][3];
   logic [QW-1:0]                qq_in [QW+1][3];
   logic                         sg_ff [QW+1][3];
   logic [DENW:0]                dv_ff [QW+1];
   region_type                   rg_ff [QW+1];
   logic [QW:0]                  vl_ff;

   logic [QW-1:0]                lim [3];
   logic [QW-1:0]                qs [3];
   logic [QW-1:0]                qv [3];
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff;

   assign wt[0] = ent.wa;
   assign wt[1] = ent.wb;
   assign wt[2] = ent.wc;

   // each weight in two slices so no multiplier grows too wide
   always_comb begin
      den1_in = DENW'(ent.wa) + DENW'(ent.wb) + DENW'(ent.wc);
      for (int k = 0; k < 3; k++) begin
         for (int ax = 0; ax < 3; ax++) begin
            pl1_in[k][ax] = $signed({1'b0, wt[k][LOW-1:0]}) * $signed(ent.vtx[k*3+ax]);
            ph1_in[k][ax] = $signed({1'b0, wt[k][WW-1:LOW]}) * $signed(ent.vtx[k*3+ax]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int ax = 0; ax < 3; ax++) begin
            wp2_in[k][ax] = (WPW'(ph1_ff[k][ax]) <<< LOW) + WPW'(pl1_ff[k][ax]);
         end
      end
   end

   // an all-zero weight set falls back to vertex a
   always_comb begin
      den3_in = den2_ff;
      for (int ax = 0; ax < 3; ax++) begin
         num3_in[ax] = NUMW'(wp2_ff[0][ax]) + NUMW'(wp2_ff[1][ax]) + NUMW'(wp2_ff[2][ax]);
      end
      if (den2_ff == '0) begin
         den3_in = DENW'(1);
         for (int ax = 0; ax < 3; ax++) begin
            num3_in[ax] = NUMW'($signed(va2_ff[ax]));
         end
      end
   end

   // round to nearest: divide 2|num| + den by 2 den
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         mag[ax]      = num3_ff[ax][NUMW-1] ? NUMW'(-num3_ff[ax]) : NUMW'(num3_ff[ax]);
         rm_in[0][ax] = RW'({mag[ax], 1'b0}) + RW'(den3_ff);
         qq_in[0][ax] = '0;
      end
   end

   for (genvar i = 0; i < QW; i++) begin : g_div
      localparam int BIT = QW - 1 - i;
      logic [RW-1:0] dsh;
      assign dsh = RW'(dv_ff[i]) << BIT;
      always_comb begin
         for (int ax = 0; ax < 3; ax++) begin
            rm_in[i+1][ax] = rm_ff[i][ax];
            qq_in[i+1][ax] = qq_ff[i][ax];
            if (rm_ff[i][ax] >= dsh) begin
               rm_in[i+1][ax]      = rm_ff[i][ax] - dsh;
               qq_in[i+1][ax][BIT] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         rm_ff[i+1] <= rm_in[i+1];
         qq_ff[i+1] <= qq_in[i+1];
         sg_ff[i+1] <= sg_ff[i];
         dv_ff[i+1] <= dv_ff[i];
         rg_ff[i+1] <= rg_ff[i];
      end
   end

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         lim[ax] = (QW'(1) << (CW - 1)) - (sg_ff[QW][ax] ? QW'(0) : QW'(1));
         qs[ax]  = (qq_ff[QW][ax] > lim[ax]) ? lim[ax] : qq_ff[QW][ax];
         qv[ax]  = sg_ff[QW][ax] ? QW'(-qs[ax]) : qs[ax];
      end
      rsp_in.near_x      = qv[0][CW-1:0];
      rsp_in.near_y      = qv[1][CW-1:0];
      rsp_in.near_z      = qv[2][CW-1:0];
      rsp_in.region_code = rg_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff        <= '0;
         vl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bv_ff        <= {bv_ff[2:1], in_valid};
         vl_ff        <= {vl_ff[QW-1:0], bv_ff[3]};
         rsp_valid_ff <= vl_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      pl1_ff  <= pl1_in;
      ph1_ff  <= ph1_in;
      den1_ff <= den1_in;
      va1_ff  <= ent.vtx[2:0];
      rg1_ff  <= ent.region;
      wp2_ff  <= wp2_in;
      den2_ff <= den1_ff;
      va2_ff  <= va1_ff;
      rg2_ff  <= rg1_ff;
      num3_ff <= num3_in;
      den3_ff <= den3_in;
      rg3_ff  <= rg2_ff;
      rm_ff[0] <= rm_in[0];
      qq_ff[0] <= qq_in[0];
      for (int ax = 0; ax < 3; ax++) begin
         sg_ff[0][ax] <= num3_ff[ax][NUMW-1];
      end
      dv_ff[0] <= {den3_ff, 1'b0};
      rg_ff[0] <= rg3_ff;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: hdl/closest_point_on_triangle.sv
// closest point on a triangle: front classifier, queue, back divider
//
//   channel   ports                      handshake
//   request   start, busy, req_data      beat taken when start and not busy
//   response  rsp_valid, rsp_data        one-cycle strobe, cannot be held off
//
// one beat per cycle is taken while busy is low. a result passes through the 7
// front stages, the queue, the weighting stages and the 17-stage rounding
// divider, one quotient bit per stage.
// reset is synchronous and clears only valid bits, pointers, the fill count and credits.
// busy rises only when queue credits run out, which a steady stream never does.
module closest_point_on_triangle import cpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic     take;
   logic     push;
   qent_type wr_ent;
   logic     rd_valid;
   qent_type rd_ent;

   assign take = start && !busy;

   cpt_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push),
      .ent   (wr_ent)
   );

   cpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .push     (push),
      .wr_ent   (wr_ent),
      .busy     (busy),
      .rd_valid (rd_valid),
      .rd_ent   (rd_ent)
   );

   cpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .ent       (rd_ent),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule
